@@ design/assert_macros.svh @@
// assertion helpers used by the parser control module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define UCFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define UCFP_ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/ucfp_pkg.sv @@
package ucfp_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int STORE_AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HEADER_FIRST  = 3'd0;
  localparam cfg_idx_t REG_HEADER_SECOND = 3'd1;
  localparam cfg_idx_t REG_CHECK_ENABLE  = 3'd2;
  localparam cfg_idx_t REG_CMD_EXCEED    = 3'd3;
  localparam cfg_idx_t REG_CMD_COUNT     = 3'd4;
  localparam cfg_idx_t REG_CMD_SHORTAGE  = 3'd5;
  localparam cfg_idx_t REG_CMD_CALIBRATE = 3'd6;
  localparam cfg_idx_t REG_CMD_DEBUG     = 3'd7;

  typedef enum logic [2:0] {
    KIND_EXCEED   = 3'd0,
    KIND_COUNT    = 3'd1,
    KIND_SHORTAGE = 3'd2,
    KIND_CALIB    = 3'd3,
    KIND_DEBUG    = 3'd4,
    KIND_UNKNOWN  = 3'd5,
    KIND_CHKERR   = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_CMDHI,
    PH_CMDLO,
    PH_LEN,
    PH_DATA,
    PH_TRAIL,
    PH_PLAY_RD,
    PH_PLAY_WR
  } phase_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic        check_enable;
    logic [15:0] cmd_exceed;
    logic [15:0] cmd_count;
    logic [15:0] cmd_shortage;
    logic [15:0] cmd_calibrate;
    logic [15:0] cmd_debug;
  } cfg_t;

  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } store_req_t;

endpackage

@@ design/uart_command_frame_parser.sv @@
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_rx_byte
// out       output     out_valid/out_stall out_kind, out_value, out_last
// cfg       input      cfg_wr_en          cfg_index, cfg_data
//
// one received word per cycle while a frame is being parsed; the trailer word
// is stalled only while the output register still holds an untaken result
// a debug frame plays its payload from the store memory, each result taking
// a memory read, then an output load, with the input stalled meanwhile
// rst_n is synchronous, active low; the payload store has no reset
// and is only read at entries written in the same frame
module uart_command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_value,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [ucfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucfp_pkg::CFG_DATA_W-1:0] cfg_data
);

  ucfp_pkg::cfg_t       cfg;
  ucfp_pkg::store_req_t store_req;
  logic [7:0]           store_rd_data;

  ucfp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ucfp_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_rd_data)
  );

  ucfp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_last      (out_last),
    .store_req     (store_req),
    .store_rd_data (store_rd_data)
  );

endmodule

@@ design/ucfp_cfg.sv @@
module ucfp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  ucfp_pkg::cfg_idx_t         cfg_index,
  input  logic [ucfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output ucfp_pkg::cfg_t             cfg
);

  ucfp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= 8'hFF;
      cfg_r.header_second <= 8'h55;
      cfg_r.check_enable  <= 1'b1;
      cfg_r.cmd_exceed    <= 16'd1;
      cfg_r.cmd_count     <= 16'd2;
      cfg_r.cmd_shortage  <= 16'd3;
      cfg_r.cmd_calibrate <= 16'd4;
      cfg_r.cmd_debug     <= 16'd5;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ucfp_pkg::REG_HEADER_FIRST:  cfg_r.header_first  <= cfg_data[7:0];
        ucfp_pkg::REG_HEADER_SECOND: cfg_r.header_second <= cfg_data[7:0];
        ucfp_pkg::REG_CHECK_ENABLE:  cfg_r.check_enable  <= cfg_data[0];
        ucfp_pkg::REG_CMD_EXCEED:    cfg_r.cmd_exceed    <= cfg_data;
        ucfp_pkg::REG_CMD_COUNT:     cfg_r.cmd_count     <= cfg_data;
        ucfp_pkg::REG_CMD_SHORTAGE:  cfg_r.cmd_shortage  <= cfg_data;
        ucfp_pkg::REG_CMD_CALIBRATE: cfg_r.cmd_calibrate <= cfg_data;
        ucfp_pkg::REG_CMD_DEBUG:     cfg_r.cmd_debug     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/ucfp_store.sv @@
module ucfp_store (
  input  logic                   clk,
  input  ucfp_pkg::store_req_t   req,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [ucfp_pkg::PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/ucfp_ctrl.sv @@
`include "assert_macros.svh"

module ucfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ucfp_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_value,
  output logic                 out_last,
  output ucfp_pkg::store_req_t store_req,
  input  logic [7:0]           store_rd_data
);

  localparam int AW = ucfp_pkg::STORE_AW;

  ucfp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]   cmd_r, cmd_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    seen_r, seen_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    fd_r, fd_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] play_last_r, play_last_nxt;

  logic          out_valid_r;
  ucfp_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [7:0]    out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_load;

  logic          playing;
  logic          in_fire;
  logic          out_free;
  logic [7:0]    b;
  logic [7:0]    seen_inc;
  logic [7:0]    fd_now;
  logic [7:0]    play_n;
  logic          chk_bad;

  assign b        = in_rx_byte;
  assign playing  = (phase_r == ucfp_pkg::PH_PLAY_RD) || (phase_r == ucfp_pkg::PH_PLAY_WR);
  assign out_free = !out_valid_r || !out_stall;
  // only the trailer word makes a result, so only it waits on the output register
  assign in_stall = playing || ((phase_r == ucfp_pkg::PH_TRAIL) && !out_free);
  assign in_fire  = in_valid && !in_stall;

  assign seen_inc = seen_r + 8'd1;
  assign fd_now   = (len_r == 8'd0) ? b : fd_r;
  assign play_n   = (len_r < ucfp_pkg::DEPTH_B) ? len_r : ucfp_pkg::DEPTH_B;
  assign chk_bad  = cfg.check_enable && ((8'd0 - sum_r) != b);

  always_comb begin
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    sum_nxt       = sum_r;
    fd_nxt        = fd_r;
    idx_nxt       = idx_r;
    play_last_nxt = play_last_r;
    out_load      = 1'b0;
    out_kind_nxt  = ucfp_pkg::KIND_UNKNOWN;
    out_value_nxt = 8'd0;
    out_last_nxt  = 1'b1;
    store_req.wr_en   = 1'b0;
    store_req.wr_addr = seen_r[AW-1:0];
    store_req.wr_data = b;
    store_req.rd_en   = 1'b0;
    store_req.rd_addr = idx_r;

    unique case (phase_r)
      ucfp_pkg::PH_HUNT1: begin
        if (in_fire && b == cfg.header_first) begin
          sum_nxt   = b;
          phase_nxt = ucfp_pkg::PH_HUNT2;
        end
      end
      ucfp_pkg::PH_HUNT2: begin
        if (in_fire) begin
          priority if (b == cfg.header_second) begin
            sum_nxt   = sum_r + b;
            phase_nxt = ucfp_pkg::PH_CMDHI;
          end else if (b == cfg.header_first) begin
            // restart the header on this word
            sum_nxt = b;
          end else begin
            phase_nxt = ucfp_pkg::PH_HUNT1;
          end
        end
      end
      ucfp_pkg::PH_CMDHI: begin
        if (in_fire) begin
          cmd_nxt   = {b, 8'd0};
          sum_nxt   = sum_r + b;
          phase_nxt = ucfp_pkg::PH_CMDLO;
        end
      end
      ucfp_pkg::PH_CMDLO: begin
        if (in_fire) begin
          cmd_nxt   = {cmd_r[15:8], b};
          sum_nxt   = sum_r + b;
          phase_nxt = ucfp_pkg::PH_LEN;
        end
      end
      ucfp_pkg::PH_LEN: begin
        if (in_fire) begin
          len_nxt   = b;
          seen_nxt  = 8'd0;
          sum_nxt   = sum_r + b;
          phase_nxt = (b == 8'd0) ? ucfp_pkg::PH_TRAIL : ucfp_pkg::PH_DATA;
        end
      end
      ucfp_pkg::PH_DATA: begin
        if (in_fire) begin
          if (seen_r == 8'd0) begin
            fd_nxt = b;
          end
          // words past the store depth are dropped
          store_req.wr_en = (seen_r < ucfp_pkg::DEPTH_B);
          seen_nxt = seen_inc;
          sum_nxt  = sum_r + b;
          if (seen_inc >= len_r) begin
            phase_nxt = ucfp_pkg::PH_TRAIL;
          end
        end
      end
      ucfp_pkg::PH_TRAIL: begin
        if (in_fire) begin
          fd_nxt    = fd_now;
          phase_nxt = ucfp_pkg::PH_HUNT1;
          out_load  = 1'b1;
          priority if (chk_bad) begin
            out_kind_nxt = ucfp_pkg::KIND_CHKERR;
          end else if (cmd_r == cfg.cmd_exceed) begin
            out_kind_nxt  = ucfp_pkg::KIND_EXCEED;
            out_value_nxt = {7'd0, fd_now == 8'd1};
          end else if (cmd_r == cfg.cmd_count) begin
            out_kind_nxt  = ucfp_pkg::KIND_COUNT;
            out_value_nxt = fd_now;
          end else if (cmd_r == cfg.cmd_shortage) begin
            out_kind_nxt  = ucfp_pkg::KIND_SHORTAGE;
            out_value_nxt = fd_now;
          end else if (cmd_r == cfg.cmd_calibrate) begin
            out_kind_nxt  = ucfp_pkg::KIND_CALIB;
            out_value_nxt = fd_now;
          end else if (cmd_r == cfg.cmd_debug) begin
            out_kind_nxt = ucfp_pkg::KIND_DEBUG;
            if (play_n != 8'd0) begin
              // play the stored payload out of the memory
              out_load      = 1'b0;
              idx_nxt       = '0;
              play_last_nxt = AW'(play_n - 8'd1);
              phase_nxt     = ucfp_pkg::PH_PLAY_RD;
            end
          end else begin
            out_kind_nxt = ucfp_pkg::KIND_UNKNOWN;
          end
        end
      end
      ucfp_pkg::PH_PLAY_RD: begin
        store_req.rd_en = 1'b1;
        phase_nxt       = ucfp_pkg::PH_PLAY_WR;
      end
      ucfp_pkg::PH_PLAY_WR: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = ucfp_pkg::KIND_DEBUG;
          out_value_nxt = store_rd_data;
          out_last_nxt  = (idx_r == play_last_r);
          if (idx_r == play_last_r) begin
            phase_nxt = ucfp_pkg::PH_HUNT1;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            phase_nxt = ucfp_pkg::PH_PLAY_RD;
          end
        end
      end
      default: phase_nxt = ucfp_pkg::PH_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ucfp_pkg::PH_HUNT1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    len_r       <= len_nxt;
    seen_r      <= seen_nxt;
    sum_r       <= sum_nxt;
    fd_r        <= fd_nxt;
    idx_r       <= idx_nxt;
    play_last_r <= play_last_nxt;
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  `UCFP_ASSERT(a_play_idx_range, playing |-> (idx_r <= play_last_r), "play index past end")
  `UCFP_ASSERT(a_load_when_free, out_load |-> out_free, "result overwrites a held word")
  `UCFP_ASSERT(a_no_input_in_play, playing |-> !in_fire, "input taken during playback")
  `UCFP_ASSERT(a_last_ends_play, (phase_r == ucfp_pkg::PH_PLAY_WR && out_load && out_last_nxt) |=> (phase_r == ucfp_pkg::PH_HUNT1), "playback did not end on last word")
  `UCFP_ASSERT_ANY(a_reset_clears_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
